// File: sv/lrpa_pkg.sv
package lrpa_pkg;

  // field widths
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int OFFSET_W = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // 24-bit bitmap row layout: rows padded to whole 32-bit words
  localparam int BITS_PER_PIXEL = 24;
  localparam int ROW_ROUND      = 31;
  localparam int ROW_WORD_BITS  = 32;
  localparam int ROW_WORD_BYTES = 4;
  localparam int ROW_SIZE_W     = 18;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH  = 3'd0,
    REG_CANVAS_HEIGHT = 3'd1,
    REG_COLOR_RED     = 3'd2,
    REG_COLOR_GREEN   = 3'd3,
    REG_COLOR_BLUE    = 3'd4
  } cfg_reg_t;

  // request kinds
  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_kind_t;

endpackage

// File: sv/lrpa_in_if.sv
interface lrpa_in_if;
  import lrpa_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;

  modport source (
    output valid, req_type, start_x, start_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

// File: sv/lrpa_out_if.sv
interface lrpa_out_if;
  import lrpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic                inside_res;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COLOR_W-1:0]  out_red;
  logic [COLOR_W-1:0]  out_green;
  logic [COLOR_W-1:0]  out_blue;
  logic                last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, inside_res, byte_offset,
           out_red, out_green, out_blue, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, inside_res, byte_offset,
           out_red, out_green, out_blue, last_pixel,
    output ready
  );
endinterface

// File: sv/line_rasterizer_pixel_address_core.sv
// Line rasterizer with 24-bit bitmap addressing. A start request (req_type 0)
// latches two endpoints and gives no pixel; each advance request (req_type 1)
// gives the next pixel of the line with its clip flag, byte offset and color,
// and last_pixel marks the end of the line. One 18x16 multiplier and a
// radix-2 restoring divider, one quotient bit per cycle, are shared under a
// small sequencer, so an advance on a sloped line runs multiply, load, 16
// divide steps, position, address multiply and offset add before the result
// register, and on a horizontal or vertical line only position, address
// multiply and offset add. A start request, or an advance with no line in
// progress, is handled in the idle state. The request side is held off while
// a pixel is computed; a finished pixel waits in the output register without
// blocking the next request.
module line_rasterizer_pixel_address_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrpa_pkg::CFG_DATA_W-1:0] cfg_data,
  lrpa_in_if.sink                        cmd,
  lrpa_out_if.source                     pix
);
  import lrpa_pkg::*;

  typedef enum logic [2:0] {
    LC_SHALLOW_UP,
    LC_STEEP_UP,
    LC_HORIZONTAL,
    LC_VERT_UP,
    LC_VERT_DOWN,
    LC_SHALLOW_DOWN,
    LC_STEEP_DOWN
  } line_case_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_POS,
    S_ADDR,
    S_OUT
  } state_t;

  localparam int DIV_STEPS = COORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int NUM_W     = 2 * COORD_W + 1;
  localparam int ROW_BITS_W = 21;

  state_t state;

  // configuration registers
  logic [COORD_W-1:0] canvas_width;
  logic [COORD_W-1:0] canvas_height;
  logic [COLOR_W-1:0] color_red;
  logic [COLOR_W-1:0] color_green;
  logic [COLOR_W-1:0] color_blue;

  // line state
  logic [COORD_W-1:0] anchor_x;
  logic [COORD_W-1:0] anchor_y;
  logic [COORD_W-1:0] far_x;
  logic [COORD_W-1:0] far_y;
  line_case_t         line_case;
  logic [COORD_W-1:0] step_position;
  logic               line_active;

  // shared datapath registers
  logic [OFFSET_W-1:0] prod;
  logic [COORD_W-1:0]  divisor;
  logic [COORD_W:0]    rem;
  logic [COORD_W-1:0]  quo;
  logic [CNT_W-1:0]    cnt;
  logic [COORD_W-1:0]  cur_x;
  logic [COORD_W-1:0]  cur_y;
  logic                cur_inside;
  logic                cur_last;

  // output register
  logic                res_valid;
  logic [COORD_W-1:0]  res_x;
  logic [COORD_W-1:0]  res_y;
  logic                res_inside;
  logic [OFFSET_W-1:0] res_offset;
  logic [COLOR_W-1:0]  res_red;
  logic [COLOR_W-1:0]  res_green;
  logic [COLOR_W-1:0]  res_blue;
  logic                res_last;

  // start request classification
  logic               swap;
  logic [COORD_W-1:0] sx, sy, ex, ey;
  logic [COORD_W-1:0] s_dx, s_up, s_down;
  line_case_t         start_case;
  logic               start_live;

  always_comb begin
    swap = cmd.start_x > cmd.end_x;
    sx = swap ? cmd.end_x   : cmd.start_x;
    sy = swap ? cmd.end_y   : cmd.start_y;
    ex = swap ? cmd.start_x : cmd.end_x;
    ey = swap ? cmd.start_y : cmd.end_y;
    s_dx   = ex - sx;
    s_up   = ey - sy;
    s_down = sy - ey;
    start_case = LC_SHALLOW_UP;
    start_live = 1'b1;
    if (sx < ex && sy < ey) begin
      start_case = (s_up <= s_dx) ? LC_SHALLOW_UP : LC_STEEP_UP;
    end else if (sx < ex && sy == ey) begin
      start_case = LC_HORIZONTAL;
    end else if (sx == ex && sy < ey) begin
      start_case = LC_VERT_UP;
    end else if (sx == ex && sy > ey) begin
      start_case = LC_VERT_DOWN;
    end else if (sy > ey) begin
      start_case = (s_down <= s_dx) ? LC_SHALLOW_DOWN : LC_STEEP_DOWN;
    end else begin
      start_live = 1'b0;
    end
  end

  // per-case major span, minor delta and pixel position
  logic [COORD_W-1:0] dx_w, dy_up, dy_dn;
  logic [COORD_W-1:0] span_w, minor_w;
  logic               sloped;
  logic               case_valid;
  logic [COORD_W-1:0] pos_x, pos_y;

  always_comb begin
    dx_w  = far_x - anchor_x;
    dy_up = far_y - anchor_y;
    dy_dn = anchor_y - far_y;
    span_w  = dx_w;
    minor_w = '0;
    sloped  = 1'b0;
    case_valid = 1'b1;
    pos_x = anchor_x;
    pos_y = anchor_y;
    case (line_case)
      LC_SHALLOW_UP: begin
        span_w = dx_w; minor_w = dy_up; sloped = 1'b1;
        pos_x = anchor_x + step_position; pos_y = anchor_y + quo;
      end
      LC_STEEP_UP: begin
        span_w = dy_up; minor_w = dx_w; sloped = 1'b1;
        pos_y = anchor_y + step_position; pos_x = anchor_x + quo;
      end
      LC_HORIZONTAL: begin
        span_w = dx_w;
        pos_x = anchor_x + step_position;
      end
      LC_VERT_UP: begin
        span_w = dy_up;
        pos_y = anchor_y + step_position;
      end
      LC_VERT_DOWN: begin
        span_w = dy_dn;
        pos_y = far_y + step_position;
      end
      LC_SHALLOW_DOWN: begin
        span_w = dx_w; minor_w = dy_dn; sloped = 1'b1;
        pos_x = anchor_x + step_position; pos_y = anchor_y - quo;
      end
      LC_STEEP_DOWN: begin
        span_w = dy_dn; minor_w = dx_w; sloped = 1'b1;
        pos_y = anchor_y - step_position; pos_x = anchor_x + quo;
      end
      default: begin
        case_valid = 1'b0;
      end
    endcase
  end

  // padded row size in bytes
  logic [ROW_BITS_W-1:0] row_bits;
  logic [ROW_SIZE_W-1:0] row_size;

  always_comb begin
    row_bits = ROW_BITS_W'(canvas_width) * ROW_BITS_W'(BITS_PER_PIXEL)
             + ROW_BITS_W'(ROW_ROUND);
    row_size = ROW_SIZE_W'((row_bits / ROW_WORD_BITS) * ROW_WORD_BYTES);
  end

  // shared multiplier
  logic [ROW_SIZE_W-1:0] mul_a;
  logic [COORD_W-1:0]    mul_b;
  logic [OFFSET_W-1:0]   mul_p;

  always_comb begin
    if (state == S_ADDR) begin
      mul_a = row_size;
      mul_b = canvas_height - cur_y;
    end else begin
      mul_a = ROW_SIZE_W'(step_position);
      mul_b = minor_w;
    end
    mul_p = OFFSET_W'(mul_a) * OFFSET_W'(mul_b);
  end

  // dividend with ceiling bias, divider step
  logic [NUM_W-1:0]   num;
  logic [COORD_W:0]   shifted;
  logic               q_bit;

  always_comb begin
    num = NUM_W'(prod[2*COORD_W-1:0]);
    if (line_case == LC_SHALLOW_DOWN) begin
      num = num + NUM_W'(divisor - 1'b1);
    end
    shifted = {rem[COORD_W-1:0], quo[COORD_W-1]};
    q_bit   = shifted >= {1'b0, divisor};
  end

  // clip test and column offset
  logic                inside_w;
  logic [COORD_W-1:0]  xm1;
  logic [COORD_W+1:0]  col_off;

  always_comb begin
    inside_w = pos_x != '0 && pos_y != '0 &&
               pos_x <= canvas_width && pos_y <= canvas_height;
    xm1     = cur_x - 1'b1;
    col_off = (COORD_W+2)'(xm1) + (COORD_W+2)'({xm1, 1'b0});
  end

  logic cmd_fire;
  logic pix_fire;
  assign cmd_fire = cmd.valid && cmd.ready;
  assign pix_fire = res_valid && pix.ready;

  assign cmd.ready = state == S_IDLE && !rst;

  // sequencer, line state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      canvas_width  <= COORD_W'(1);
      canvas_height <= COORD_W'(1);
      color_red     <= '0;
      color_green   <= '0;
      color_blue    <= '0;
      anchor_x      <= '0;
      anchor_y      <= '0;
      far_x         <= '0;
      far_y         <= '0;
      line_case     <= LC_SHALLOW_UP;
      step_position <= '0;
      line_active   <= 1'b0;
      cnt           <= '0;
      res_valid     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
          REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
          REG_COLOR_RED:     color_red     <= cfg_data[COLOR_W-1:0];
          REG_COLOR_GREEN:   color_green   <= cfg_data[COLOR_W-1:0];
          REG_COLOR_BLUE:    color_blue    <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end

      if (pix_fire && state != S_OUT) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (req_kind_t'(cmd.req_type) == REQ_START) begin
              anchor_x      <= sx;
              anchor_y      <= sy;
              far_x         <= ex;
              far_y         <= ey;
              step_position <= '0;
              line_case     <= start_case;
              line_active   <= start_live;
            end else if (line_active) begin
              if (!case_valid) begin
                line_active <= 1'b0;
              end else if (sloped) begin
                state <= S_MUL;
              end else begin
                state <= S_POS;
              end
            end
          end
        end
        S_MUL: begin
          prod    <= mul_p;
          divisor <= span_w;
          state   <= S_LOAD;
        end
        S_LOAD: begin
          rem   <= num[NUM_W-1:COORD_W];
          quo   <= num[COORD_W-1:0];
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= q_bit ? (shifted - {1'b0, divisor}) : shifted;
          quo <= {quo[COORD_W-2:0], q_bit};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          cur_x      <= pos_x;
          cur_y      <= pos_y;
          cur_inside <= inside_w;
          cur_last   <= step_position >= span_w;
          if (step_position >= span_w) begin
            line_active <= 1'b0;
          end else begin
            step_position <= step_position + 1'b1;
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          prod  <= mul_p;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || pix.ready) begin
            res_valid  <= 1'b1;
            res_x      <= cur_x;
            res_y      <= cur_y;
            res_inside <= cur_inside;
            res_offset <= cur_inside ? prod + OFFSET_W'(col_off) : '0;
            res_red    <= color_red;
            res_green  <= color_green;
            res_blue   <= color_blue;
            res_last   <= cur_last;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign pix.valid       = res_valid;
  assign pix.pixel_x     = res_x;
  assign pix.pixel_y     = res_y;
  assign pix.inside_res  = res_inside;
  assign pix.byte_offset = res_offset;
  assign pix.out_red     = res_red;
  assign pix.out_green   = res_green;
  assign pix.out_blue    = res_blue;
  assign pix.last_pixel  = res_last;

endmodule

// File: dv/tb_line_rasterizer_pixel_address_core.sv
module tb_line_rasterizer_pixel_address_core;
  import lrpa_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 30;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int MAX_COORD       = 65535;
  localparam int NEAR_SPAN       = 12;
  localparam int NO_CAP          = 100000;

  // register indexes past the end of the list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef enum logic [2:0] {
    LN_SHALLOW_UP,
    LN_STEEP_UP,
    LN_HORIZONTAL,
    LN_VERT_UP,
    LN_VERT_DOWN,
    LN_SHALLOW_DOWN,
    LN_STEEP_DOWN
  } line_shape_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                in_canvas;
    logic [OFFSET_W-1:0] offset;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic                last;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lrpa_in_if  cmd_if ();
  lrpa_out_if pix_if ();

  line_rasterizer_pixel_address_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .pix       (pix_if)
  );

  // canvas and color copy
  logic [COORD_W-1:0] canvas_w;
  logic [COORD_W-1:0] canvas_h;
  logic [COLOR_W-1:0] paint_r;
  logic [COLOR_W-1:0] paint_g;
  logic [COLOR_W-1:0] paint_b;

  // line in progress
  logic [COORD_W-1:0] anchor_x;
  logic [COORD_W-1:0] anchor_y;
  logic [COORD_W-1:0] far_x;
  logic [COORD_W-1:0] far_y;
  line_shape_t        shape;
  logic [COORD_W-1:0] step_pos;
  logic               line_on;

  pixel_t pixel_queue[$];

  bit src_idling  = 1'b1;
  bit sink_idling = 1'b1;
  int hold_cycles = 0;
  int cycle_count;
  int items_sent      = 0;
  int pixels_checked  = 0;
  int clipped_seen    = 0;
  int line_ends_seen  = 0;
  int settings_used   = 0;
  int error_count     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void reset_canvas_state();
    canvas_w = 16'd1;
    canvas_h = 16'd1;
    paint_r  = '0;
    paint_g  = '0;
    paint_b  = '0;
    anchor_x = '0;
    anchor_y = '0;
    far_x    = '0;
    far_y    = '0;
    shape    = LN_SHALLOW_UP;
    step_pos = '0;
    line_on  = 1'b0;
  endfunction

  // latch endpoints, order by x and classify the line
  function automatic void begin_line(input logic [COORD_W-1:0] sx, sy, ex, ey);
    logic [COORD_W-1:0] t;
    if (sx > ex) begin
      t = sx; sx = ex; ex = t;
      t = sy; sy = ey; ey = t;
    end
    anchor_x = sx;
    anchor_y = sy;
    far_x    = ex;
    far_y    = ey;
    step_pos = '0;
    line_on  = 1'b1;
    if (sx < ex && sy < ey) begin
      shape = (ey - sy <= ex - sx) ? LN_SHALLOW_UP : LN_STEEP_UP;
    end else if (sx < ex && sy == ey) begin
      shape = LN_HORIZONTAL;
    end else if (sx == ex && sy < ey) begin
      shape = LN_VERT_UP;
    end else if (sx == ex && sy > ey) begin
      shape = LN_VERT_DOWN;
    end else if (sy > ey) begin
      shape = (sy - ey <= ex - sx) ? LN_SHALLOW_DOWN : LN_STEEP_DOWN;
    end else begin
      // both endpoints the same: nothing to draw
      shape   = LN_SHALLOW_UP;
      line_on = 1'b0;
    end
  endfunction

  // next pixel of the current line, returns 0 when no line is in progress
  function automatic bit trace_pixel(output pixel_t px);
    logic [63:0] k, dx, dy, span, q, row_bytes, offs;
    logic [COORD_W-1:0] x, y;
    bit in_canvas;
    px = '0;
    if (!line_on) return 1'b0;
    k  = 64'(step_pos);
    dx = 64'(far_x) - 64'(anchor_x);
    case (shape)
      LN_SHALLOW_UP: begin
        dy   = 64'(far_y) - 64'(anchor_y);
        span = dx;
        x    = COORD_W'(64'(anchor_x) + k);
        y    = COORD_W'(64'(anchor_y) + (k * dy) / dx);
      end
      LN_STEEP_UP: begin
        dy   = 64'(far_y) - 64'(anchor_y);
        span = dy;
        y    = COORD_W'(64'(anchor_y) + k);
        x    = COORD_W'(64'(anchor_x) + (k * dx) / dy);
      end
      LN_HORIZONTAL: begin
        span = dx;
        x    = COORD_W'(64'(anchor_x) + k);
        y    = anchor_y;
      end
      LN_VERT_UP: begin
        span = 64'(far_y) - 64'(anchor_y);
        x    = anchor_x;
        y    = COORD_W'(64'(anchor_y) + k);
      end
      LN_VERT_DOWN: begin
        // walks from the lower y upward
        span = 64'(anchor_y) - 64'(far_y);
        x    = anchor_x;
        y    = COORD_W'(64'(far_y) + k);
      end
      LN_SHALLOW_DOWN: begin
        // ceiling of the quotient here
        dy   = 64'(anchor_y) - 64'(far_y);
        span = dx;
        q    = (k * dy + dx - 64'd1) / dx;
        x    = COORD_W'(64'(anchor_x) + k);
        y    = COORD_W'(64'(anchor_y) - q);
      end
      LN_STEEP_DOWN: begin
        dy   = 64'(anchor_y) - 64'(far_y);
        span = dy;
        y    = COORD_W'(64'(anchor_y) - k);
        x    = COORD_W'(64'(anchor_x) + (k * dx) / dy);
      end
      default: begin
        line_on = 1'b0;
        return 1'b0;
      end
    endcase

    // clip against the 1-based canvas, bottom-up padded rows
    in_canvas = x != 0 && y != 0 && x <= canvas_w && y <= canvas_h;
    offs = '0;
    if (in_canvas) begin
      row_bytes = ((64'(BITS_PER_PIXEL) * 64'(canvas_w) + 64'(ROW_ROUND))
                   / 64'(ROW_WORD_BITS)) * 64'(ROW_WORD_BYTES);
      offs = row_bytes * (64'(canvas_h) - 64'(y))
             + (64'(x) - 64'd1) * 64'(BITS_PER_PIXEL / 8);
    end

    px.x         = x;
    px.y         = y;
    px.in_canvas = in_canvas;
    px.offset    = offs[OFFSET_W-1:0];
    px.red       = paint_r;
    px.green     = paint_g;
    px.blue      = paint_b;
    px.last      = (k >= span);

    if (k >= span) line_on = 1'b0;
    else step_pos = COORD_W'(k + 64'd1);
    return 1'b1;
  endfunction

  // pixels still to come on the current line
  function automatic int pixels_left();
    int a, b;
    if (!line_on) return 0;
    a = int'(far_x) - int'(anchor_x);
    b = (far_y > anchor_y) ? int'(far_y) - int'(anchor_y) : int'(anchor_y) - int'(far_y);
    return ((a > b) ? a : b) + 1 - int'(step_pos);
  endfunction

  function automatic logic [COORD_W-1:0] pick_base(input logic [COORD_W-1:0] dim);
    int lim;
    lim = int'(dim) + 2;
    if (lim > MAX_COORD) lim = MAX_COORD;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return COORD_W'($urandom);
      default: return COORD_W'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN;
    if (v < 0) v = 0;
    if (v > MAX_COORD) v = MAX_COORD;
    return COORD_W'(v);
  endfunction

  task automatic report_error(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // one request on the command channel, predicted when accepted
  task automatic send_request(input req_kind_t kind,
                              input logic [COORD_W-1:0] sx, sy, ex, ey);
    pixel_t px;
    if (src_idling && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.req_type <= kind;
    cmd_if.start_x  <= sx;
    cmd_if.start_y  <= sy;
    cmd_if.end_x    <= ex;
    cmd_if.end_y    <= ey;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    items_sent++;
    if (kind == REQ_START) begin
      begin_line(sx, sy, ex, ey);
    end else if (trace_pixel(px)) begin
      pixel_queue.insert(pixel_queue.size(), px);
    end
  endtask

  // start a line and advance through it, stopping after cap advances
  task automatic draw_line(input logic [COORD_W-1:0] sx, sy, ex, ey,
                           input int extra, input int cap);
    int n;
    send_request(REQ_START, sx, sy, ex, ey);
    n = pixels_left() + extra;
    if (n > cap) n = cap;
    repeat (n)
      send_request(REQ_ADVANCE, COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // stop sending and wait for every pending pixel plus the pipeline tail
  task automatic quiesce();
    cmd_if.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_CANVAS_WIDTH:  canvas_w = data;
      REG_CANVAS_HEIGHT: canvas_h = data;
      REG_COLOR_RED:     paint_r  = data[COLOR_W-1:0];
      REG_COLOR_GREEN:   paint_g  = data[COLOR_W-1:0];
      REG_COLOR_BLUE:    paint_b  = data[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // colors go out with junk in the upper data bits
  task automatic configure(input logic [COORD_W-1:0] w, h,
                           input logic [COLOR_W-1:0] r, g, b);
    quiesce();
    set_register(REG_CANVAS_WIDTH, w);
    set_register(REG_CANVAS_HEIGHT, h);
    set_register(REG_COLOR_RED, {COLOR_W'($urandom), r});
    set_register(REG_COLOR_GREEN, {COLOR_W'($urandom), g});
    set_register(REG_COLOR_BLUE, {COLOR_W'($urandom), b});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mostly complete short lines near the canvas, some long, cut or stray
  task automatic random_lines(input int budget);
    int first, pick;
    logic [COORD_W-1:0] bx, by;
    first = items_sent;
    while (items_sent - first < budget) begin
      pick = $urandom_range(0, 19);
      bx = pick_base(canvas_w);
      by = pick_base(canvas_h);
      if (pick == 0) begin
        send_request(REQ_ADVANCE, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom));
        send_request(REQ_START, bx, by, near_coord(bx), near_coord(by));
      end else if (pick == 1) begin
        draw_line(bx, by, near_coord(bx), near_coord(by), 0, $urandom_range(0, 4));
      end else if (pick <= 3) begin
        draw_line(bx, by, COORD_W'($urandom), COORD_W'($urandom), 0,
                  $urandom_range(1, 30));
      end else begin
        draw_line(bx, by, near_coord(bx), near_coord(by),
                  ($urandom_range(0, 3) == 0) ? 1 : 0, NO_CAP);
      end
    end
  endtask

  // reset canvas 1x1 with black
  task automatic test_reset_canvas();
    random_lines(40);
  endtask

  // each line shape once, identical endpoints, advance with no line
  task automatic test_line_cases();
    configure(16'd20, 16'd15, 8'h12, 8'hC3, 8'h7E);
    draw_line(16'd5, 16'd5, 16'd5, 16'd5, 1, NO_CAP);
    draw_line(16'd0, 16'd0, 16'd1, 16'd1, 0, NO_CAP);
    draw_line(16'd1, 16'd1, 16'd2, 16'd3, 0, NO_CAP);
    draw_line(16'hFFFE, 16'd0, 16'hFFFF, 16'd0, 0, NO_CAP);
    draw_line(16'd3, 16'd4, 16'd3, 16'd5, 0, NO_CAP);
    draw_line(16'd0, 16'hFFFF, 16'd0, 16'hFFFE, 0, NO_CAP);
    // swapped endpoints, then one advance past the end
    draw_line(16'd2, 16'd1, 16'd1, 16'd2, 1, NO_CAP);
    draw_line(16'd1, 16'd3, 16'd2, 16'd1, 0, NO_CAP);
  endtask

  // canvas extremes, including zero width and zero height
  task automatic test_canvas_sweep();
    configure(16'd24, 16'd18, 8'($urandom), 8'($urandom), 8'($urandom));
    random_lines(70);
    configure(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    random_lines(70);
    configure(16'd1, 16'd1, 8'h00, 8'hFF, 8'h00);
    random_lines(70);
    configure(16'd0, 16'd40, 8'($urandom), 8'($urandom), 8'($urandom));
    random_lines(60);
    configure(16'd33, 16'd0, 8'($urandom), 8'($urandom), 8'($urandom));
    random_lines(60);
  endtask

  // writes past the register list must leave the setting alone
  task automatic test_spare_registers();
    configure(16'd12, 16'd9, 8'($urandom), 8'($urandom), 8'($urandom));
    @(posedge clk);
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      set_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    random_lines(40);
  endtask

  // receiver holds off while requests keep coming, input must stall
  task automatic test_backpressure();
    configure(16'd30, 16'd20, 8'($urandom), 8'($urandom), 8'($urandom));
    hold_cycles = HOLD_OFF_CYCLES;
    random_lines(100);
  endtask

  // back to back requests with the receiver always ready
  task automatic test_steady_stream();
    configure(COORD_W'($urandom_range(1, 64)), COORD_W'($urandom_range(1, 64)),
              8'($urandom), 8'($urandom), 8'($urandom));
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    random_lines(100);
  endtask

  // pixel receiver with random stall bursts and the long hold-off
  initial begin : pixel_receiver
    int burst;
    pix_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        pix_if.ready <= 1'b0;
        hold_cycles--;
      end else if (sink_idling && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 6);
        pix_if.ready <= 1'b0;
        repeat (burst - 1) @(posedge clk);
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  // compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin : pixel_check
    pixel_t got, want;
    if (!rst && pix_if.valid === 1'b1 && pix_if.ready === 1'b1) begin
      got.x         = pix_if.pixel_x;
      got.y         = pix_if.pixel_y;
      got.in_canvas = pix_if.inside_res;
      got.offset    = pix_if.byte_offset;
      got.red       = pix_if.out_red;
      got.green     = pix_if.out_green;
      got.blue      = pix_if.out_blue;
      got.last      = pix_if.last_pixel;
      if (pixel_queue.size() == 0) begin
        report_error($sformatf("pixel (%0d,%0d) with none pending", got.x, got.y));
      end else begin
        want = pixel_queue.pop_front();
        pixels_checked++;
        if (!want.in_canvas) clipped_seen++;
        if (want.last) line_ends_seen++;
        if (got.x !== want.x)
          report_error($sformatf("pixel_x %0d, want %0d", got.x, want.x));
        if (got.y !== want.y)
          report_error($sformatf("pixel_y %0d, want %0d", got.y, want.y));
        if (got.in_canvas !== want.in_canvas)
          report_error($sformatf("inside_res %0d, want %0d at (%0d,%0d)",
                                 got.in_canvas, want.in_canvas, want.x, want.y));
        if (got.offset !== want.offset)
          report_error($sformatf("byte_offset %0d, want %0d at (%0d,%0d)",
                                 got.offset, want.offset, want.x, want.y));
        if (got.red !== want.red)
          report_error($sformatf("out_red %0h, want %0h", got.red, want.red));
        if (got.green !== want.green)
          report_error($sformatf("out_green %0h, want %0h", got.green, want.green));
        if (got.blue !== want.blue)
          report_error($sformatf("out_blue %0h, want %0h", got.blue, want.blue));
        if (got.last !== want.last)
          report_error($sformatf("last_pixel %0d, want %0d at (%0d,%0d)",
                                 got.last, want.last, want.x, want.y));
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles with %0d pixels pending",
             cycle_count, pixel_queue.size());
    $display("[line_rasterizer_pixel_address_core] ERROR");
    $finish;
  end

  // test sequence
  initial begin : run_tests
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    cmd_if.valid    = 1'b0;
    cmd_if.req_type = REQ_START;
    cmd_if.start_x  = '0;
    cmd_if.start_y  = '0;
    cmd_if.end_x    = '0;
    cmd_if.end_y    = '0;
    reset_canvas_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_canvas();
    test_line_cases();
    test_canvas_sweep();
    test_spare_registers();
    test_backpressure();
    test_steady_stream();
    quiesce();

    $display("%0d requests over %0d canvas settings, %0d pixels checked",
             items_sent, settings_used, pixels_checked);
    $display("%0d pixels clipped, %0d line ends seen", clipped_seen, line_ends_seen);
    if (error_count == 0)
      $display("[line_rasterizer_pixel_address_core] OK");
    else
      $display("[line_rasterizer_pixel_address_core] ERROR");
    $finish;
  end

endmodule

// File: line_rasterizer_pixel_address_core.f
sv/lrpa_pkg.sv
sv/lrpa_in_if.sv
sv/lrpa_out_if.sv
sv/line_rasterizer_pixel_address_core.sv
dv/tb_line_rasterizer_pixel_address_core.sv
